>>> hw/rtl/assert_macros.svh
// Assertion macros for the top RTL file of the move-to-front word decompressor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks a property at every rising clock edge outside reset.
`define ASSERT_AT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition never holds at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_AT(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

>>> hw/rtl/mwd_pkg.sv
// Shared types, character codes and helper functions of the move-to-front word decompressor.
package mwd_pkg;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;

  localparam int POS_W = 9;
  localparam logic [POS_W-1:0] POS_MAX = 9'd511;

  // Wide enough for a cell index at the largest supported list depth.
  localparam int IDX_MAX_W = 12;

  typedef logic [IDX_MAX_W-1:0] cell_idx_t;

  typedef struct packed {
    logic      shift;
    cell_idx_t limit;
  } cell_ctrl_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FIND  = 5'b00010,
    S_LEN   = 5'b00100,
    S_EMIT  = 5'b01000,
    S_FINAL = 5'b10000
  } state_t;

  function automatic logic is_letter(input logic [7:0] b);
    is_letter = (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) ||
                (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    is_digit = (b >= CHAR_ZERO && b <= CHAR_NINE);
  endfunction

endpackage

>>> hw/rtl/mwd_cell.sv
// One cell of the recency chain: holds the slot number of one list position.
module mwd_cell #(
  parameter int IDX = 0,
  parameter int SW  = 8
) (
  input  logic                clk,
  input  mwd_pkg::cell_ctrl_t ctrl,
  input  logic [SW-1:0]       slot_in,
  output logic [SW-1:0]       slot,
  output logic [SW-1:0]       hit_slot
);

  // Cells up to and including the limit take their neighbor's slot.
  always_ff @(posedge clk) begin
    if (ctrl.shift && (ctrl.limit >= mwd_pkg::cell_idx_t'(IDX))) begin
      slot <= slot_in;
    end
  end

  assign hit_slot = (ctrl.limit == mwd_pkg::cell_idx_t'(IDX)) ? slot : '0;

endmodule

>>> hw/rtl/mtf_word_decompressor.sv
// Move-to-front word decompressor: each non-digit code beat yields one text beat, or a
// stored word then one text beat; digit beats yield none. A byte that ends a valid
// position run holds off code beats until the recalled word and that byte are out. Word
// bytes come out one per cycle unless the text output stalls, via the single read port
// of the word memory, after steps that pick the slot from the chain and read its length.
// Recency order is a chain of LIST_DEPTH cells holding slot numbers; word bytes and lengths
// live in memories addressed by slot, so no clearing pass follows reset.
`include "assert_macros.svh"

module mtf_word_decompressor #(
  parameter int LIST_DEPTH = 256,
  parameter int WORD_LEN   = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       code_valid,
  output logic       code_stall,
  input  logic [7:0] in_byte,
  output logic       text_valid,
  input  logic       text_stall,
  output logic [7:0] out_byte,
  output logic       last_of_run,
  output logic       error_flag
);

  localparam int IW   = $clog2(LIST_DEPTH);
  localparam int CW   = $clog2(LIST_DEPTH + 1);
  localparam int BW   = $clog2(WORD_LEN);
  localparam int LW   = $clog2(WORD_LEN + 1);
  localparam int PW   = mwd_pkg::POS_W;
  localparam int CMPW = (CW > PW) ? CW : PW;
  localparam int MW   = PW + 4;
  localparam int WMEM_DEPTH = LIST_DEPTH << BW;

  mwd_pkg::state_t state;
  mwd_pkg::state_t state_next;

  logic [CW-1:0] count;
  logic [LW-1:0] pend_len;
  logic [PW-1:0] accum;
  logic          in_number;
  logic [7:0]    hold_byte;
  logic [IW-1:0] sel_k;
  logic [IW-1:0] sel_slot;
  logic [LW-1:0] len_q;
  logic [BW-1:0] emit_i;
  logic [7:0]    rd_data;

  logic [7:0]    word_mem [WMEM_DEPTH];
  logic [LW-1:0] len_mem  [LIST_DEPTH];

  logic [IW-1:0] cell_slot [LIST_DEPTH];
  logic [IW-1:0] hit_slot  [LIST_DEPTH];
  logic [IW-1:0] hit_or;
  logic [IW-1:0] insert_slot;
  mwd_pkg::cell_ctrl_t chain_ctrl;

  logic          ld_ok;
  logic          acc;
  logic          dig;
  logic [3:0]    dval;
  logic [MW-1:0] accum_ext;
  logic [PW-1:0] accum_sat;
  logic          p_ok;
  logic          full;
  logic [IW-1:0] pslot;
  logic [7:0]    fin_byte;
  logic          fin_letter;
  logic          room;
  logic          fin_err;
  logic          do_finish;
  logic          do_push;
  logic          do_letter;
  logic          do_mtf;
  logic          do_emit;
  logic          emit_last;
  logic          rd_en;
  logic [IW+BW-1:0] rd_addr;
  logic          ld;
  logic [7:0]    ld_byte;
  logic          ld_last;
  logic          ld_err;
  logic          recall_busy;

  genvar gi;
  generate
    for (gi = 0; gi < LIST_DEPTH; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        mwd_cell #(.IDX(gi), .SW(IW)) u_cell (
          .clk      (clk),
          .ctrl     (chain_ctrl),
          .slot_in  (insert_slot),
          .slot     (cell_slot[gi]),
          .hit_slot (hit_slot[gi])
        );
      end else begin : g_body
        mwd_cell #(.IDX(gi), .SW(IW)) u_cell (
          .clk      (clk),
          .ctrl     (chain_ctrl),
          .slot_in  (cell_slot[gi-1]),
          .slot     (cell_slot[gi]),
          .hit_slot (hit_slot[gi])
        );
      end
    end
  endgenerate

  always_comb begin
    hit_or = '0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      hit_or = hit_or | hit_slot[i];
    end
  end

  assign ld_ok      = !text_valid || !text_stall;
  assign code_stall = !((state == mwd_pkg::S_IDLE) && ld_ok);
  assign acc        = code_valid && !code_stall;
  assign dig        = mwd_pkg::is_digit(in_byte);
  assign dval       = 4'(in_byte - mwd_pkg::CHAR_ZERO);
  assign accum_ext  = (MW'(accum) << 3) + (MW'(accum) << 1) + MW'(dval);
  assign accum_sat  = (accum_ext > MW'(mwd_pkg::POS_MAX)) ? mwd_pkg::POS_MAX : PW'(accum_ext);
  assign p_ok       = (accum != '0) && (CMPW'(accum) <= CMPW'(count));
  assign full       = (count == CW'(LIST_DEPTH));
  assign pslot      = full ? cell_slot[LIST_DEPTH-1] : IW'(count);

  // The byte that closes a beat: the accepted byte, or the one held over a word recall.
  assign fin_byte   = (state == mwd_pkg::S_FINAL) ? hold_byte : in_byte;
  assign fin_letter = mwd_pkg::is_letter(fin_byte);
  assign room       = pend_len < LW'(WORD_LEN);
  assign fin_err    = ((state == mwd_pkg::S_IDLE) && in_number) || (fin_letter && !room);

  assign do_finish = (acc && !dig && !(in_number && p_ok)) ||
                     ((state == mwd_pkg::S_FINAL) && ld_ok);
  assign do_push   = (pend_len != '0) &&
                     ((acc && dig && !in_number) || (do_finish && !fin_letter));
  assign do_letter = do_finish && fin_letter && room;
  assign do_mtf    = (state == mwd_pkg::S_FIND);
  assign do_emit   = (state == mwd_pkg::S_EMIT) && ld_ok;
  assign emit_last = ((LW'(emit_i) + LW'(1)) == len_q);

  assign recall_busy = (state == mwd_pkg::S_FIND) || (state == mwd_pkg::S_LEN) ||
                       (state == mwd_pkg::S_EMIT);

  always_comb begin
    chain_ctrl.shift = do_push || do_mtf;
    chain_ctrl.limit = do_mtf ? mwd_pkg::cell_idx_t'(sel_k) :
                                mwd_pkg::cell_idx_t'(LIST_DEPTH - 1);
    insert_slot      = do_mtf ? hit_or : pslot;
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = {sel_slot, {BW{1'b0}}};
    if (state == mwd_pkg::S_LEN) begin
      rd_en = 1'b1;
    end else if (do_emit && !emit_last) begin
      rd_en   = 1'b1;
      rd_addr = {sel_slot, emit_i + BW'(1)};
    end
  end

  always_comb begin
    ld      = do_finish || do_emit;
    ld_byte = do_emit ? rd_data : fin_byte;
    ld_last = !do_emit;
    ld_err  = do_emit ? 1'b0 : fin_err;
  end

  always_comb begin
    state_next = state;
    case (state)
      mwd_pkg::S_IDLE: begin
        if (acc && !dig && in_number && p_ok) begin
          state_next = mwd_pkg::S_FIND;
        end
      end
      mwd_pkg::S_FIND: begin
        state_next = mwd_pkg::S_LEN;
      end
      mwd_pkg::S_LEN: begin
        state_next = mwd_pkg::S_EMIT;
      end
      mwd_pkg::S_EMIT: begin
        if (do_emit && emit_last) begin
          state_next = mwd_pkg::S_FINAL;
        end
      end
      mwd_pkg::S_FINAL: begin
        if (ld_ok) begin
          state_next = mwd_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = mwd_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= mwd_pkg::S_IDLE;
      count      <= '0;
      pend_len   <= '0;
      accum      <= '0;
      in_number  <= 1'b0;
      text_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (do_push) begin
        pend_len <= '0;
        if (!full) begin
          count <= count + CW'(1);
        end
      end else if (do_letter) begin
        pend_len <= pend_len + LW'(1);
      end
      if (acc && dig) begin
        in_number <= 1'b1;
        accum     <= in_number ? accum_sat : PW'(dval);
      end else if (acc) begin
        in_number <= 1'b0;
        accum     <= '0;
      end
      if (ld) begin
        text_valid <= 1'b1;
      end else if (!text_stall) begin
        text_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      hold_byte <= in_byte;
      sel_k     <= IW'(accum - PW'(1));
    end
    if (do_mtf) begin
      sel_slot <= hit_or;
    end
    if (state == mwd_pkg::S_LEN) begin
      emit_i <= '0;
    end else if (do_emit) begin
      emit_i <= emit_i + BW'(1);
    end
    if (ld) begin
      out_byte    <= ld_byte;
      last_of_run <= ld_last;
      error_flag  <= ld_err;
    end
  end

  always_ff @(posedge clk) begin
    if (do_letter) begin
      word_mem[{pslot, BW'(pend_len)}] <= fin_byte;
    end
    if (rd_en) begin
      rd_data <= word_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      len_mem[pslot] <= pend_len;
    end
    if (state == mwd_pkg::S_LEN) begin
      len_q <= len_mem[sel_slot];
    end
  end

  `ASSERT_AT(a_count_bound, clk, rst, count <= CW'(LIST_DEPTH), "list count above depth")
  `ASSERT_AT(a_number_no_pending, clk, rst, in_number |-> (pend_len == '0), "pending word in a run")
  `ASSERT_AT(a_recall_no_pending, clk, rst, recall_busy |-> (pend_len == '0), "pending in recall")
  `ASSERT_NEVER(a_emit_flags, clk, rst, do_emit && ld_err, "error flagged on a recalled byte")

endmodule
